### rtl/clrt_pkg.sv
// shared types and constants for the cache lock region table
package clrt_pkg;

   localparam int ADDR_W         = 48;
   localparam int SIZE_W         = 32;
   localparam int OPCODE_W       = 2;
   localparam int STATUS_W       = 2;
   localparam int SLOT_OUT_W     = 3;
   localparam int REGION_COUNT_W = 4;
   localparam int CSR_INDEX_W    = 2;
   localparam int CSR_DATA_W     = 32;

   localparam logic [OPCODE_W-1:0] OP_LOCK    = 2'd0;
   localparam logic [OPCODE_W-1:0] OP_QUERY   = 2'd1;
   localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_INVALID = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_BUSY    = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_REGION_COUNT    = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_LOCK_BUDGET     = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_REGION_SIZE = 2'd2;

   localparam logic [REGION_COUNT_W-1:0] REGION_COUNT_RESET    = 4'd8;
   localparam logic [SIZE_W-1:0]         LOCK_BUDGET_RESET     = 32'd0;
   localparam logic [SIZE_W-1:0]         MIN_REGION_SIZE_RESET = 32'd64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CHECK,
      ST_MOD,
      ST_BUDGET,
      ST_FREE,
      ST_RD,
      ST_CMP
   } state_type;

endpackage

### rtl/clrt_ram.sv
// generic single-port-write ram with registered read
module clrt_ram #(
   parameter int WIDTH = 80,
   parameter int DEPTH = 8
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic                                      re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/clrt_mod_unit.sv
// bit-serial remainder unit, tells whether the address is a multiple of the size
module clrt_mod_unit (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [clrt_pkg::ADDR_W-1:0] dividend,
   input  logic [clrt_pkg::SIZE_W-1:0] divisor,
   output logic                        done,
   output logic                        rem_zero
);
   import clrt_pkg::*;

   localparam int CntW = $clog2(ADDR_W + 1);

   logic              run_ff, run_in;
   logic              done_ff, done_in;
   logic [CntW-1:0]   cnt_ff, cnt_in;
   logic [ADDR_W-1:0] dvd_ff, dvd_in;
   logic [SIZE_W-1:0] div_ff, div_in;
   logic [SIZE_W-1:0] rem_ff, rem_in;
   logic [SIZE_W:0]   shifted;
   logic [SIZE_W:0]   diff;

   always_comb begin
      shifted = {rem_ff, dvd_ff[ADDR_W-1]};
      diff    = shifted - {1'b0, div_ff};
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      div_in  = div_ff;
      rem_in  = rem_ff;
      if (start) begin
         run_in = 1'b1;
         cnt_in = '0;
         dvd_in = dividend;
         div_in = divisor;
         rem_in = '0;
      end else if (run_ff) begin
         dvd_in = {dvd_ff[ADDR_W-2:0], 1'b0};
         // borrow set means the shifted remainder is below the divisor
         rem_in = diff[SIZE_W] ? shifted[SIZE_W-1:0] : diff[SIZE_W-1:0];
         cnt_in = cnt_ff + CntW'(1);
         if (cnt_ff == CntW'(ADDR_W - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      div_ff <= div_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign rem_zero = (rem_ff == '0);

endmodule

### rtl/cache_lock_region_table_core.sv
// cache lock region table: lock, query and release of cache lock regions
// lock: request check, a serial modulo when region_count is 1, budget check, then a free slot scan
// query and release: a scan of the active slots, one registered ram read and one compare per slot
// a new request is accepted only while idle; busy is high from acceptance until the result strobe
// synchronous reset clears the state machine, valid bits, total and result strobe, and loads the csr reset values
// entry ram holds no reset; entry contents are only used behind their valid bits
module cache_lock_region_table_core #(
   parameter int MAX_REGIONS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [clrt_pkg::OPCODE_W-1:0]       req_opcode,
   input  logic [clrt_pkg::ADDR_W-1:0]         req_address,
   input  logic [clrt_pkg::SIZE_W-1:0]         req_region_size,
   output logic                                rsp_valid,
   output logic [clrt_pkg::STATUS_W-1:0]       rsp_status,
   output logic [clrt_pkg::SLOT_OUT_W-1:0]     rsp_slot,
   output logic [clrt_pkg::SIZE_W-1:0]         rsp_locked_bytes,
   input  logic                                csr_we,
   input  logic [clrt_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [clrt_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import clrt_pkg::*;

   localparam int SlotW  = MAX_REGIONS > 1 ? $clog2(MAX_REGIONS) : 1;
   localparam int IdxW   = $clog2(MAX_REGIONS + 1);
   localparam int CmpW   = IdxW > REGION_COUNT_W ? IdxW : REGION_COUNT_W;
   localparam int EntryW = ADDR_W + SIZE_W;

   state_type                 state_ff, state_in;
   logic [REGION_COUNT_W-1:0] region_count_ff;
   logic [SIZE_W-1:0]         lock_budget_ff;
   logic [SIZE_W-1:0]         min_region_size_ff;
   logic [OPCODE_W-1:0]       op_ff;
   logic [ADDR_W-1:0]         addr_ff;
   logic [SIZE_W-1:0]         size_ff;
   logic [IdxW-1:0]           idx_ff;
   logic [MAX_REGIONS-1:0]    valid_ff;
   logic [SIZE_W-1:0]         total_ff, total_in;
   logic                      rsp_valid_ff;
   logic [STATUS_W-1:0]       rsp_status_ff;
   logic [SLOT_OUT_W-1:0]     rsp_slot_ff;

   logic                  accept;
   logic [CmpW-1:0]       count_ext;
   logic [CmpW-1:0]       active_n;
   logic                  idx_end;
   logic [SlotW-1:0]      idx_slot;
   logic                  cur_valid;
   logic                  size_bad;
   logic                  one_region;
   logic                  over_budget;
   logic                  hit;
   logic [EntryW-1:0]     ram_rdata;
   logic [ADDR_W-1:0]     rd_addr;
   logic [SIZE_W-1:0]     rd_size;
   logic                  mod_done;
   logic                  mod_rem_zero;

   logic                  done;
   logic [STATUS_W-1:0]   done_status;
   logic [SLOT_OUT_W-1:0] done_slot;
   logic                  ram_we;
   logic                  ram_re;
   logic                  idx_inc;
   logic                  valid_set;
   logic                  valid_clr;
   logic                  mod_start;

   assign accept     = start && (state_ff == ST_IDLE);
   assign count_ext  = CmpW'(region_count_ff);
   assign active_n   = (count_ext > CmpW'(MAX_REGIONS)) ? CmpW'(MAX_REGIONS) : count_ext;
   assign idx_end    = (CmpW'(idx_ff) >= active_n);
   assign idx_slot   = idx_ff[SlotW-1:0];
   assign cur_valid  = valid_ff[idx_slot];
   assign size_bad   = (size_ff < min_region_size_ff);
   assign one_region = (region_count_ff == REGION_COUNT_W'(1));
   assign over_budget = ({1'b0, size_ff} + {1'b0, total_ff}) > {1'b0, lock_budget_ff};
   assign rd_addr    = ram_rdata[EntryW-1:SIZE_W];
   assign rd_size    = ram_rdata[SIZE_W-1:0];
   assign hit        = cur_valid && (rd_addr == addr_ff);

   clrt_ram #(
      .WIDTH(EntryW),
      .DEPTH(MAX_REGIONS)
   ) u_entry_ram (
      .clock(clock),
      .we   (ram_we),
      .waddr(idx_slot),
      .wdata({addr_ff, size_ff}),
      .re   (ram_re),
      .raddr(idx_slot),
      .rdata(ram_rdata)
   );

   clrt_mod_unit u_mod (
      .clock   (clock),
      .reset   (reset),
      .start   (mod_start),
      .dividend(addr_ff),
      .divisor (size_ff),
      .done    (mod_done),
      .rem_zero(mod_rem_zero)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if (op_ff == OP_LOCK) begin
               priority if (size_bad) begin
                  state_in = ST_IDLE;
               end else if (one_region && (size_ff != '0)) begin
                  state_in = ST_MOD;
               end else if (one_region) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_BUDGET;
               end
            end else if ((op_ff == OP_QUERY) || (op_ff == OP_RELEASE)) begin
               state_in = ST_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MOD: begin
            if (mod_done) begin
               state_in = mod_rem_zero ? ST_BUDGET : ST_IDLE;
            end
         end
         ST_BUDGET: begin
            state_in = over_budget ? ST_IDLE : ST_FREE;
         end
         ST_FREE: begin
            if (idx_end || !cur_valid) begin
               state_in = ST_IDLE;
            end
         end
         ST_RD: begin
            state_in = idx_end ? ST_IDLE : ST_CMP;
         end
         ST_CMP: begin
            state_in = hit ? ST_IDLE : ST_RD;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      done        = 1'b0;
      done_status = STATUS_INVALID;
      done_slot   = '0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      idx_inc     = 1'b0;
      valid_set   = 1'b0;
      valid_clr   = 1'b0;
      mod_start   = 1'b0;
      total_in    = total_ff;
      unique case (state_ff)
         ST_IDLE: begin
         end
         ST_CHECK: begin
            if (op_ff == OP_LOCK) begin
               priority if (size_bad) begin
                  done = 1'b1;
               end else if (one_region && (size_ff != '0)) begin
                  mod_start = 1'b1;
               end else if (one_region) begin
                  done = 1'b1;
               end else begin
               end
            end else if ((op_ff != OP_QUERY) && (op_ff != OP_RELEASE)) begin
               done = 1'b1;
            end
         end
         ST_MOD: begin
            if (mod_done && !mod_rem_zero) begin
               done = 1'b1;
            end
         end
         ST_BUDGET: begin
            if (over_budget) begin
               done        = 1'b1;
               done_status = STATUS_BUSY;
            end
         end
         ST_FREE: begin
            priority if (idx_end) begin
               done        = 1'b1;
               done_status = STATUS_BUSY;
            end else if (!cur_valid) begin
               done        = 1'b1;
               done_status = STATUS_OK;
               done_slot   = SLOT_OUT_W'(idx_ff);
               ram_we      = 1'b1;
               valid_set   = 1'b1;
               total_in    = total_ff + size_ff;
            end else begin
               idx_inc = 1'b1;
            end
         end
         ST_RD: begin
            if (idx_end) begin
               done = 1'b1;
            end else begin
               ram_re = 1'b1;
            end
         end
         ST_CMP: begin
            if (hit) begin
               done        = 1'b1;
               done_status = STATUS_OK;
               done_slot   = SLOT_OUT_W'(idx_ff);
               if (op_ff == OP_RELEASE) begin
                  valid_clr = 1'b1;
                  total_in  = total_ff - rd_size;
               end
            end else begin
               idx_inc = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff           <= ST_IDLE;
         region_count_ff    <= REGION_COUNT_RESET;
         lock_budget_ff     <= LOCK_BUDGET_RESET;
         min_region_size_ff <= MIN_REGION_SIZE_RESET;
         valid_ff           <= '0;
         total_ff           <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         rsp_valid_ff <= done;
         if (valid_set) begin
            valid_ff[idx_slot] <= 1'b1;
         end
         if (valid_clr) begin
            valid_ff[idx_slot] <= 1'b0;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_REGION_COUNT:    region_count_ff    <= csr_wdata[REGION_COUNT_W-1:0];
               CSR_LOCK_BUDGET:     lock_budget_ff     <= csr_wdata[SIZE_W-1:0];
               CSR_MIN_REGION_SIZE: min_region_size_ff <= csr_wdata[SIZE_W-1:0];
               default: begin
               end
            endcase
         end
      end
      if (accept) begin
         op_ff   <= req_opcode;
         addr_ff <= req_address;
         size_ff <= req_region_size;
         idx_ff  <= '0;
      end else if (idx_inc) begin
         idx_ff <= idx_ff + IdxW'(1);
      end
      if (done) begin
         rsp_status_ff <= done_status;
         rsp_slot_ff   <= done_slot;
      end
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_locked_bytes = total_ff;

endmodule

### rtl/clrt_checker.sv
// port-level checker for the cache lock region table, bound to the top level
module clrt_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic                            rsp_valid,
   input logic [clrt_pkg::STATUS_W-1:0]   rsp_status,
   input logic [clrt_pkg::SLOT_OUT_W-1:0] rsp_slot
);
   import clrt_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("accepted request did not raise busy");

   a_done_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_valid)
      else $error("busy dropped without a result");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_slot == '0))
      else $error("nonzero slot on a failed request");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_OK) || (rsp_status == STATUS_INVALID) ||
                     (rsp_status == STATUS_BUSY)))
      else $error("unknown status code");

endmodule

bind cache_lock_region_table_core clrt_checker u_clrt_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_status(rsp_status),
   .rsp_slot  (rsp_slot)
);
